FILE: hw/rtl/wsd_pkg.sv
// Package for the WAV byte stream to DAC sample converter.
// Shared constants, the result struct and the sample code function.
// No dependencies.
package wsd_pkg;

  localparam int unsigned HeaderBytesDefault = 44;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned FieldW  = 16;
  localparam int unsigned CodeW   = 12;
  localparam int unsigned PhaseW  = 2;

  // Header byte offsets of the little-endian fields
  localparam int unsigned PosChannels = 22;
  localparam int unsigned PosRate     = 24;
  localparam int unsigned PosAlign    = 32;

  // Supported block align / channel count pairs
  localparam logic [FieldW-1:0] Align8     = 16'd1;
  localparam logic [FieldW-1:0] AlignMono  = 16'd2;
  localparam logic [FieldW-1:0] AlignStero = 16'd4;
  localparam logic [FieldW-1:0] ChanMono   = 16'd1;
  localparam logic [FieldW-1:0] ChanStereo = 16'd2;

  typedef struct packed {
    logic              valid;
    logic [CodeW-1:0]  sample_value;
    logic              channel;
    logic              eight_bit;
    logic [FieldW-1:0] rate_hz;
  } result_t;

  // Sign flip of the 16-bit sample then shift right by 4
  function automatic logic [CodeW-1:0] to_code(input logic [ByteW-1:0] lo,
                                               input logic [ByteW-1:0] hi);
    to_code = {~hi[7], hi[6:0], lo[7:4]};
  endfunction

endpackage

FILE: hw/rtl/wsd_stream_if.sv
// Stream interfaces for the WAV converter: byte input and sample output.
// Depends on wsd_pkg.
interface wsd_byte_if;
  logic                     valid;
  logic                     ready;
  logic [wsd_pkg::ByteW-1:0] data_byte;
  logic                     first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface wsd_sample_if;
  logic                      valid;
  logic                      ready;
  logic [wsd_pkg::CodeW-1:0]  sample_value;
  logic                      channel;
  logic                      eight_bit;
  logic [wsd_pkg::FieldW-1:0] rate_hz;

  modport source (output valid, output sample_value, output channel, output eight_bit,
                  output rate_hz, input ready);
  modport sink   (input valid, input sample_value, input channel, input eight_bit,
                  input rate_hz, output ready);
endinterface

FILE: hw/rtl/wsd_frame_core.sv
// Header capture and sample framing state for the WAV converter.
// Updates state on step_i and presents the result for the current word.
// Depends on wsd_pkg.
module wsd_frame_core #(
  parameter int unsigned HeaderBytes = wsd_pkg::HeaderBytesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [wsd_pkg::ByteW-1:0] data_byte_i,
  input  logic                      first_byte_i,
  output wsd_pkg::result_t          res_o
);
  localparam int unsigned PosW = $clog2(HeaderBytes + 1);
  localparam logic [PosW-1:0] PosHdr   = PosW'(HeaderBytes);
  localparam logic [PosW-1:0] PosChLo  = PosW'(wsd_pkg::PosChannels);
  localparam logic [PosW-1:0] PosChHi  = PosW'(wsd_pkg::PosChannels + 1);
  localparam logic [PosW-1:0] PosRtLo  = PosW'(wsd_pkg::PosRate);
  localparam logic [PosW-1:0] PosRtHi  = PosW'(wsd_pkg::PosRate + 1);
  localparam logic [PosW-1:0] PosAlLo  = PosW'(wsd_pkg::PosAlign);
  localparam logic [PosW-1:0] PosAlHi  = PosW'(wsd_pkg::PosAlign + 1);

  logic [PosW-1:0]                 pos_q, pos_d, pos_e;
  logic [wsd_pkg::ByteW-1:0]       low_q, low_d, low_e;
  logic [wsd_pkg::PhaseW-1:0]      phase_q, phase_d, phase_e;
  logic [wsd_pkg::FieldW-1:0]      rate_q, rate_d, rate_e;
  logic [wsd_pkg::FieldW-1:0]      chan_q, chan_d, chan_e;
  logic [wsd_pkg::FieldW-1:0]      align_q, align_d, align_e;
  logic                            fmt_mono, fmt_stereo;

  always_comb begin
    // a file start clears everything before this word is taken
    pos_e   = first_byte_i ? '0 : pos_q;
    low_e   = first_byte_i ? '0 : low_q;
    phase_e = first_byte_i ? '0 : phase_q;
    rate_e  = first_byte_i ? '0 : rate_q;
    chan_e  = first_byte_i ? '0 : chan_q;
    align_e = first_byte_i ? '0 : align_q;

    pos_d   = pos_e;
    low_d   = low_e;
    phase_d = phase_e;
    rate_d  = rate_e;
    chan_d  = chan_e;
    align_d = align_e;

    fmt_mono   = (align_e == wsd_pkg::AlignMono) && (chan_e == wsd_pkg::ChanMono);
    fmt_stereo = (align_e == wsd_pkg::AlignStero) && (chan_e == wsd_pkg::ChanStereo);

    res_o          = '0;
    res_o.rate_hz  = rate_e;

    if (pos_e < PosHdr) begin
      if (pos_e == PosChLo) chan_d[7:0]   = data_byte_i;
      if (pos_e == PosChHi) chan_d[15:8]  = data_byte_i;
      if (pos_e == PosRtLo) rate_d[7:0]   = data_byte_i;
      if (pos_e == PosRtHi) rate_d[15:8]  = data_byte_i;
      if (pos_e == PosAlLo) align_d[7:0]  = data_byte_i;
      if (pos_e == PosAlHi) align_d[15:8] = data_byte_i;
      pos_d = pos_e + PosW'(1);
    end else if (align_e == wsd_pkg::Align8) begin
      res_o.valid        = 1'b1;
      res_o.eight_bit    = 1'b1;
      res_o.sample_value = {{(wsd_pkg::CodeW - wsd_pkg::ByteW){1'b0}}, data_byte_i};
    end else if (fmt_mono || fmt_stereo) begin
      // mono wraps after two bytes, stereo after four
      if (fmt_mono ? (phase_e >= 2'd1) : (phase_e == 2'd3)) phase_d = '0;
      else                                                  phase_d = phase_e + 2'd1;
      if (!phase_e[0]) begin
        low_d = data_byte_i;
      end else begin
        res_o.valid        = 1'b1;
        res_o.channel      = phase_e[1];
        res_o.sample_value = wsd_pkg::to_code(low_e, data_byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      low_q   <= '0;
      phase_q <= '0;
      rate_q  <= '0;
      chan_q  <= '0;
      align_q <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      low_q   <= low_d;
      phase_q <= phase_d;
      rate_q  <= rate_d;
      chan_q  <= chan_d;
      align_q <= align_d;
    end
  end

endmodule

FILE: hw/rtl/wav_stream_to_dac_samples.sv
// Top level of the WAV byte stream to DAC sample converter.
// Input word register, framing core and output result register.
// Depends on wsd_pkg, wsd_stream_if and wsd_frame_core.
//
// Usage:
//   byte_i carries the WAV file one byte per word; first_byte marks the first
//   byte of a file and restarts header capture. The first HeaderBytes bytes
//   are header and give no sample. sample_o carries one DAC code per 8-bit
//   byte, or one per 16-bit little-endian sample (mono or stereo, channel
//   tags left/right). Unsupported formats and header bytes give no word.
//   A byte accepted into the input register passes the framing core into the
//   output register and shows on sample_o from there. Throughput: one byte
//   per cycle unless sample_o stalls, as each register holds one word.
//   When sample_o stalls, the output register holds its word and the input
//   register still takes one more byte; byte_i.ready then drops until the
//   output is taken.
//   Reset clears all header fields, the byte counter and both register
//   valids; bytes after reset count as header as if a file had begun.
module wav_stream_to_dac_samples #(
  parameter int unsigned HeaderBytes = wsd_pkg::HeaderBytesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wsd_byte_if.sink     byte_i,
  wsd_sample_if.source sample_o
);
  logic                      in_vld_q;
  logic [wsd_pkg::ByteW-1:0] in_byte_q;
  logic                      in_first_q;
  logic                      advance;
  wsd_pkg::result_t          res;
  wsd_pkg::result_t          out_q;

  assign advance      = in_vld_q && (!out_q.valid || sample_o.ready);
  assign byte_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q  <= byte_i.data_byte;
      in_first_q <= byte_i.first_byte;
    end
  end

  wsd_frame_core #(
    .HeaderBytes(HeaderBytes)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .data_byte_i (in_byte_q),
    .first_byte_i(in_first_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (advance) begin
      out_q <= res;
    end else if (sample_o.ready) begin
      out_q.valid <= 1'b0;
    end
  end

  assign sample_o.valid        = out_q.valid;
  assign sample_o.sample_value = out_q.sample_value;
  assign sample_o.channel      = out_q.channel;
  assign sample_o.eight_bit    = out_q.eight_bit;
  assign sample_o.rate_hz      = out_q.rate_hz;

endmodule
